// ----- design/rbd_pkg.sv -----
// rbd_pkg: request codes, status codes and the cell control bundle
// for the ring buffer deque. No dependencies.
package rbd_pkg;

    localparam int CMD_BITS    = 3;
    localparam int STATUS_BITS = 2;
    localparam int OCC_BITS    = 4;
    localparam int VALUE_BITS  = 32;

    localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_PEEK_BACK  = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    // one-cycle shift/update command broadcast to every cell
    typedef struct packed {
        logic ins_front;
        logic ins_back;
        logic rem_front;
        logic rem_back;
    } t_cell_ctl;

endpackage

// ----- design/ring_buffer_deque_top.sv -----
// ring_buffer_deque_top: fixed-capacity double-ended queue built as a chain
// of rbd_cell storage cells. Depends on rbd_pkg and rbd_cell.
//
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries i_cmd and
//   i_push_value. Result channel (o_out_valid / i_out_ready) carries
//   o_read_value, o_status, o_occupancy, o_is_empty and o_is_full.
//   Every request transaction yields exactly one result transaction.
//   The front word always sits in cell 0; the back word is the last valid
//   cell. Push front shifts the whole chain one cell back, pop front shifts
//   it one cell forward, push back fills the first free cell, pop back
//   clears the last valid one.
//   The result is registered: it is loaded into the output register on the
//   clock edge that accepts the request.
//   Throughput: one request per cycle, limited by the single output
//   register; a request is taken whenever that register is empty or is
//   being drained in the same cycle.
//   Receiver stall: the result holds in the output register and o_in_ready
//   drops until it is taken; queue state does not change meanwhile.
//   Reset: all cells empty, count zero, no result pending. Stored words are
//   not cleared; only valid cells are ever read.
module ring_buffer_deque_top #(
    parameter int DEPTH     = 8,
    parameter int WORD_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [rbd_pkg::CMD_BITS-1:0]           i_cmd,
    input  logic signed [rbd_pkg::VALUE_BITS-1:0]  i_push_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [rbd_pkg::VALUE_BITS-1:0]  o_read_value,
    output logic [rbd_pkg::STATUS_BITS-1:0]        o_status,
    output logic [rbd_pkg::OCC_BITS-1:0]           o_occupancy,
    output logic                                   o_is_empty,
    output logic                                   o_is_full
);
    import rbd_pkg::*;

    // words are masked to 32 bits on entry, so never store more than that
    localparam int SW    = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic [VALUE_BITS-1:0]  r_read_value;
    logic [STATUS_BITS-1:0] r_status;
    logic [STATUS_BITS-1:0] n_status;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic [SW-1:0]    w_push_data;
    logic [SW-1:0]    w_back_word;
    logic [SW-1:0]    n_read;
    t_cell_ctl        w_ctl_req;
    t_cell_ctl        w_ctl;

    logic [SW-1:0]    w_word [DEPTH];
    logic             w_valid [DEPTH];
    logic [SW-1:0]    w_tap [DEPTH];

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_push_data = i_push_value[SW-1:0];

    // ---- cell chain: cell 0 holds the front word ----
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [SW-1:0] w_lw;
            logic          w_lv;
            logic [SW-1:0] w_rw;
            logic          w_rv;
            if (gi == 0) begin : g_first
                // left of the front cell: the incoming word, always present
                assign w_lw = w_push_data;
                assign w_lv = 1'b1;
            end else begin : g_mid
                assign w_lw = w_word[gi-1];
                assign w_lv = w_valid[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_rw = '0;
                assign w_rv = 1'b0;
            end else begin : g_inner
                assign w_rw = w_word[gi+1];
                assign w_rv = w_valid[gi+1];
            end
            rbd_cell #(
                .W(SW)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_push_data   (w_push_data),
                .i_left_word   (w_lw),
                .i_left_valid  (w_lv),
                .i_right_word  (w_rw),
                .i_right_valid (w_rv),
                .o_word        (w_word[gi]),
                .o_valid       (w_valid[gi]),
                .o_back_tap    (w_tap[gi])
            );
        end
    endgenerate

    // only the last valid cell drives its tap, so an OR picks the back word
    always_comb begin
        w_back_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_back_word = w_back_word | w_tap[k];
        end
    end

    // ---- request decode ----
    always_comb begin
        w_ctl_req = '0;
        n_status  = ST_DONE;
        n_read    = '0;
        n_count   = r_count;
        unique case (i_cmd)
            CMD_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl_req.ins_front = 1'b1;
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl_req.ins_back = 1'b1;
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl_req.rem_front = 1'b1;
                    n_read  = w_word[0];
                    n_count = CNT_W'(r_count - 1'b1);
                end
            end
            CMD_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl_req.rem_back = 1'b1;
                    n_read  = w_back_word;
                    n_count = CNT_W'(r_count - 1'b1);
                end
            end
            CMD_PEEK_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_read = w_word[0];
                end
            end
            CMD_PEEK_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_read = w_back_word;
                end
            end
            default: begin
                // unknown request: no change, reports current count
            end
        endcase
    end

    // chain only moves on an accepted transaction
    assign w_ctl = w_accept ? w_ctl_req : '0;

    // ---- count and output register ----
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= VALUE_BITS'(n_read);
            r_status     <= n_status;
        end
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // count only changes on accept, so flags follow the registered count
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_occupancy  = OCC_BITS'(r_count);
    assign o_is_empty   = w_empty;
    assign o_is_full    = w_full;

endmodule

// ----- design/rbd_cell.sv -----
// rbd_cell: one storage cell of the deque chain (word plus valid bit).
// Depends on rbd_pkg for the control bundle.
module rbd_cell #(
    parameter int W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbd_pkg::t_cell_ctl i_ctl,
    input  logic [W-1:0]       i_push_data,
    input  logic [W-1:0]       i_left_word,
    input  logic               i_left_valid,
    input  logic [W-1:0]       i_right_word,
    input  logic               i_right_valid,
    output logic [W-1:0]       o_word,
    output logic               o_valid,
    output logic [W-1:0]       o_back_tap
);
    import rbd_pkg::*;

    logic [W-1:0] r_word;
    logic [W-1:0] n_word;
    logic         r_valid;
    logic         n_valid;
    logic         w_is_last;

    assign w_is_last  = r_valid && !i_right_valid;
    assign o_word     = r_word;
    assign o_valid    = r_valid;
    assign o_back_tap = w_is_last ? r_word : '0;

    always_comb begin
        n_word  = r_word;
        n_valid = r_valid;
        priority if (i_ctl.ins_front) begin
            // shift toward the back; cell 0 sees the new word on its left
            n_word  = i_left_word;
            n_valid = i_left_valid;
        end else if (i_ctl.ins_back) begin
            if (!r_valid && i_left_valid) begin
                n_word  = i_push_data;
                n_valid = 1'b1;
            end
        end else if (i_ctl.rem_front) begin
            n_word  = i_right_word;
            n_valid = i_right_valid;
        end else if (i_ctl.rem_back) begin
            if (w_is_last) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule
